>>> sv/braille_command_line_parser_core_macros.svh
// assertion helpers shared by the parser rtl
`ifndef BRAILLE_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`define BRAILLE_COMMAND_LINE_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define BCLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bclp_pkg.sv
package bclp_pkg;

    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 3;
    localparam int DOTS_W   = 6;
    localparam int LETTER_W = 5;
    localparam int CHAN_W   = 3;
    localparam int RESULT_W = CODE_W + DOTS_W + LETTER_W + CHAN_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TILDE    = 8'h7E;
    localparam logic [CHAR_W-1:0] CHAR_QUESTION = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_T  = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_CASE_BIT = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_FIVE     = 8'h35;

    typedef enum logic [CODE_W-1:0] {
        CODE_LETTER = 3'd0,
        CODE_TEST   = 3'd1,
        CODE_DIAG   = 3'd2,
        CODE_LONG   = 3'd3,
        CODE_BAD    = 3'd4,
        CODE_ABSENT = 3'd5
    } result_code_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   test_channel;
        logic [LETTER_W-1:0] letter_index;
        logic [DOTS_W-1:0]   dot_pattern;
        result_code_t        result_code;
    } result_t;

    // six-dot cell, bit i is dot i+1
    function automatic logic [DOTS_W-1:0] dot_lookup(input logic [LETTER_W-1:0] letter);
        logic [DOTS_W-1:0] dots;
        begin
            unique case (letter)
                5'd0:    dots = 6'h01;
                5'd1:    dots = 6'h03;
                5'd2:    dots = 6'h09;
                5'd3:    dots = 6'h19;
                5'd4:    dots = 6'h11;
                5'd5:    dots = 6'h0B;
                5'd6:    dots = 6'h1B;
                5'd7:    dots = 6'h13;
                5'd8:    dots = 6'h0A;
                5'd9:    dots = 6'h1A;
                5'd10:   dots = 6'h05;
                5'd11:   dots = 6'h07;
                5'd12:   dots = 6'h0D;
                5'd13:   dots = 6'h1D;
                5'd14:   dots = 6'h15;
                5'd15:   dots = 6'h0F;
                5'd16:   dots = 6'h1F;
                5'd17:   dots = 6'h17;
                5'd18:   dots = 6'h0E;
                5'd19:   dots = 6'h1E;
                5'd20:   dots = 6'h25;
                5'd21:   dots = 6'h27;
                5'd22:   dots = 6'h3A;
                5'd23:   dots = 6'h2D;
                5'd24:   dots = 6'h3D;
                5'd25:   dots = 6'h35;
                default: dots = '0;
            endcase
            return dots;
        end
    endfunction

endpackage

>>> sv/bclp_classify.sv
module bclp_classify (
    input  logic [bclp_pkg::CHAR_W-1:0] first_char,
    input  logic [bclp_pkg::CHAR_W-1:0] second_char,
    input  logic                        count_one,
    input  logic                        count_two,
    input  logic                        overlong,
    input  logic                        driver_present,
    output bclp_pkg::result_t           result
);

    logic [bclp_pkg::CHAR_W-1:0]   upper_char;
    logic                          is_letter;
    logic                          is_test;
    logic [bclp_pkg::CHAR_W-1:0]   letter_offset;
    logic [bclp_pkg::CHAR_W-1:0]   chan_offset;
    logic [bclp_pkg::LETTER_W-1:0] letter;

    always_comb
    begin
        if (first_char >= bclp_pkg::CHAR_LOWER_A && first_char <= bclp_pkg::CHAR_LOWER_Z)
        begin
            upper_char = first_char - bclp_pkg::CHAR_CASE_BIT;
        end
        else
        begin
            upper_char = first_char;
        end
    end

    assign letter_offset = upper_char - bclp_pkg::CHAR_UPPER_A;
    assign chan_offset   = second_char - bclp_pkg::CHAR_ZERO;
    assign letter        = letter_offset[bclp_pkg::LETTER_W-1:0];
    assign is_letter     = count_one && upper_char >= bclp_pkg::CHAR_UPPER_A &&
                           upper_char <= bclp_pkg::CHAR_UPPER_Z;
    assign is_test       = count_two && upper_char == bclp_pkg::CHAR_UPPER_T &&
                           second_char >= bclp_pkg::CHAR_ZERO &&
                           second_char <= bclp_pkg::CHAR_FIVE;

    always_comb
    begin
        result = '{test_channel: '0, letter_index: '0, dot_pattern: '0,
                   result_code: bclp_pkg::CODE_BAD};
        priority if (overlong)
        begin
            result.result_code = bclp_pkg::CODE_LONG;
        end
        else if (count_one && first_char == bclp_pkg::CHAR_QUESTION)
        begin
            result.result_code = bclp_pkg::CODE_DIAG;
        end
        else if (is_letter)
        begin
            if (driver_present)
            begin
                result.result_code  = bclp_pkg::CODE_LETTER;
                result.letter_index = letter;
                result.dot_pattern  = bclp_pkg::dot_lookup(letter);
            end
            else
            begin
                result.result_code = bclp_pkg::CODE_ABSENT;
            end
        end
        else if (is_test)
        begin
            if (driver_present)
            begin
                result.result_code  = bclp_pkg::CODE_TEST;
                result.test_channel = chan_offset[bclp_pkg::CHAN_W-1:0];
            end
            else
            begin
                result.result_code = bclp_pkg::CODE_ABSENT;
            end
        end
        else
        begin
            result.result_code = bclp_pkg::CODE_BAD;
        end
    end

endmodule

>>> sv/braille_command_line_parser_core.sv
// Serial command line parser: one received byte per request on s_axis, one classified
// command per non-empty or overlong line on m_axis. Each accepted byte lands in an input
// register and is folded into the line state from there, so a byte is taken every cycle
// while no result waits, and a line-end byte loads its result into the output register
// as it is folded in. Bytes stall only while a finished result waits to be taken.
// driver_present resets to 1; the user writes it through the cfg channel only while the parser is idle (not enforced).
module braille_command_line_parser_core #(
    parameter int MAX_LINE_CHARS = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,        // driver_present
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bclp_pkg::CHAR_W-1:0]     s_axis_tdata,    // rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_code[2:0], dot_pattern[8:3], letter_index[13:9], test_channel[16:14], zero pad
    output logic [bclp_pkg::TDATA_W-1:0]    m_axis_tdata
);

`include "braille_command_line_parser_core_macros.svh"

    localparam int COUNT_W = $clog2(MAX_LINE_CHARS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_LINE_CHARS);

    logic                        driver_present_reg;
    logic                        in_valid_reg,  in_valid_next;
    logic [bclp_pkg::CHAR_W-1:0] in_byte_reg;
    logic [COUNT_W-1:0]          count_reg,     count_next;
    logic                        overlong_reg,  overlong_next;
    logic [bclp_pkg::CHAR_W-1:0] first_reg,     first_next;
    logic [bclp_pkg::CHAR_W-1:0] second_reg,    second_next;
    logic                        out_valid_reg, out_valid_next;
    bclp_pkg::result_t           out_reg;

    logic              advance;
    logic              is_eol;
    logic              is_printable;
    logic              emit;
    bclp_pkg::result_t result;

    assign cfg_ready = 1'b1;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign is_eol       = in_byte_reg == bclp_pkg::CHAR_CR || in_byte_reg == bclp_pkg::CHAR_LF;
    assign is_printable = in_byte_reg >= bclp_pkg::CHAR_SPACE &&
                          in_byte_reg <= bclp_pkg::CHAR_TILDE;
    assign emit         = advance && is_eol && (count_reg != '0 || overlong_reg);

    bclp_classify u_classify (
        .first_char     (first_reg),
        .second_char    (second_reg),
        .count_one      (count_reg == COUNT_W'(1)),
        .count_two      (count_reg == COUNT_W'(2)),
        .overlong       (overlong_reg),
        .driver_present (driver_present_reg),
        .result         (result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        count_next     = count_reg;
        overlong_next  = overlong_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            count_next     = '0;
            overlong_next  = 1'b0;
            first_next     = '0;
            second_next    = '0;
        end
        else if (advance && is_printable)
        begin
            if (count_reg < COUNT_MAX)
            begin
                if (count_reg == '0)
                begin
                    first_next = in_byte_reg;
                end
                else if (count_reg == COUNT_W'(1))
                begin
                    second_next = in_byte_reg;
                end
                count_next = count_reg + COUNT_W'(1);
            end
            else
            begin
                overlong_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driver_present_reg <= 1'b1;
            in_valid_reg       <= 1'b0;
            count_reg          <= '0;
            overlong_reg       <= 1'b0;
            first_reg          <= '0;
            second_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                driver_present_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            count_reg     <= count_next;
            overlong_reg  <= overlong_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = bclp_pkg::TDATA_W'(out_reg);

    `BCLP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_MAX, "line count above limit")
    `BCLP_ASSERT_NOW(a_overlong_full, overlong_reg, count_reg == COUNT_MAX, "overlong before full")
    `BCLP_ASSERT_NEXT(a_line_clear, emit, count_reg == '0 && !overlong_reg && m_axis_tvalid, "line state not cleared after result")
    `BCLP_ASSERT_NEXT(a_input_hold, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg), "staged byte lost while stalled")
    `BCLP_ASSERT_NOW(a_dots_only_letter, m_axis_tvalid && out_reg.result_code != bclp_pkg::CODE_LETTER, out_reg.dot_pattern == '0 && out_reg.letter_index == '0, "letter fields set on non-letter result")

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX      = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 132;
    localparam int PHASE_COUNT   = 8;
    localparam int RUN_LIMIT     = 400000;

    localparam logic [bclp_pkg::DOTS_W-1:0] BRAILLE_CELLS [26] = '{
        6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
        6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
        6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
    };

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [7:0]         value;
        bit                 pinned;
        bclp_pkg::result_t  want;
    } dir_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [bclp_pkg::CHAR_W-1:0]   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [bclp_pkg::TDATA_W-1:0]  m_axis_tdata;

    // line state of the predictor
    int                   ln_count;
    bit                   ln_overlong;
    logic [7:0]           ln_first;
    logic [7:0]           ln_second;
    bit                   drv_present;

    bclp_pkg::result_t    pending_cmds[$];
    dir_row_t             dir_rows[$];
    flow_t                flow;
    logic                 squeeze_go;
    logic                 rx_hold;
    int                   errors;
    int                   cycles;
    int                   bytes_sent;
    int                   cmds_seen;
    int                   code_hits[6];
    int                   cfg_writes;
    int                   longest_stall;

    braille_command_line_parser_core #(
        .MAX_LINE_CHARS(LINE_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("watchdog: cycle limit of %0d reached", RUN_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        end
    endtask

    // line state update and command classification for one byte
    task automatic parse_byte(input logic [7:0] ch, output bit produced,
                              output bclp_pkg::result_t r);
        logic [7:0] up;
        begin
            produced = 1'b0;
            r = '0;
            if (ch == bclp_pkg::CHAR_CR || ch == bclp_pkg::CHAR_LF)
            begin
                if (ln_count != 0 || ln_overlong)
                begin
                    produced = 1'b1;
                    up = ln_first;
                    if (up >= bclp_pkg::CHAR_LOWER_A && up <= bclp_pkg::CHAR_LOWER_Z)
                        up = up - bclp_pkg::CHAR_CASE_BIT;
                    r.result_code = bclp_pkg::CODE_BAD;
                    if (ln_overlong)
                        r.result_code = bclp_pkg::CODE_LONG;
                    else if (ln_count == 1 && ln_first == bclp_pkg::CHAR_QUESTION)
                        r.result_code = bclp_pkg::CODE_DIAG;
                    else if (ln_count == 1 && up >= bclp_pkg::CHAR_UPPER_A &&
                             up <= bclp_pkg::CHAR_UPPER_Z)
                    begin
                        if (drv_present)
                        begin
                            r.result_code  = bclp_pkg::CODE_LETTER;
                            r.letter_index = bclp_pkg::LETTER_W'(up - bclp_pkg::CHAR_UPPER_A);
                            r.dot_pattern  = BRAILLE_CELLS[int'(up - bclp_pkg::CHAR_UPPER_A)];
                        end
                        else
                            r.result_code = bclp_pkg::CODE_ABSENT;
                    end
                    else if (ln_count == 2 && up == bclp_pkg::CHAR_UPPER_T &&
                             ln_second >= bclp_pkg::CHAR_ZERO &&
                             ln_second <= bclp_pkg::CHAR_FIVE)
                    begin
                        if (drv_present)
                        begin
                            r.result_code  = bclp_pkg::CODE_TEST;
                            r.test_channel = bclp_pkg::CHAN_W'(ln_second - bclp_pkg::CHAR_ZERO);
                        end
                        else
                            r.result_code = bclp_pkg::CODE_ABSENT;
                    end
                    ln_count    = 0;
                    ln_overlong = 1'b0;
                    ln_first    = '0;
                    ln_second   = '0;
                end
            end
            else if (ch >= bclp_pkg::CHAR_SPACE && ch <= bclp_pkg::CHAR_TILDE)
            begin
                if (ln_count < LINE_MAX)
                begin
                    if (ln_count == 0)
                        ln_first = ch;
                    else if (ln_count == 1)
                        ln_second = ch;
                    ln_count++;
                end
                else
                    ln_overlong = 1'b1;
            end
        end
    endtask

    function automatic bit src_idle();
        begin
            if (flow == FLOW_SRC_IDLE)
                return $urandom_range(99) < 83;
            if (flow == FLOW_BOTH)
                return $urandom_range(99) < 11;
            return 1'b0;
        end
    endfunction

    function automatic bit sink_stall();
        begin
            if (flow == FLOW_SINK_STALL)
                return $urandom_range(99) < 83;
            if (flow == FLOW_BOTH)
                return $urandom_range(99) < 11;
            return 1'b0;
        end
    endfunction

    function automatic logic [7:0] printable_byte();
        begin
            return 8'($urandom_range(bclp_pkg::CHAR_TILDE, bclp_pkg::CHAR_SPACE));
        end
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] v;
        begin
            v = 8'($urandom_range(255));
            while ((v >= bclp_pkg::CHAR_SPACE && v <= bclp_pkg::CHAR_TILDE) ||
                   v == bclp_pkg::CHAR_CR || v == bclp_pkg::CHAR_LF)
                v = 8'($urandom_range(255));
            return v;
        end
    endfunction

    // one byte request; the expected command goes on the queue once accepted
    task automatic send_char(input logic [7:0] ch, input bit pinned,
                             input bclp_pkg::result_t pin);
        bit                produced;
        bclp_pkg::result_t r;
        int                waited;
        begin
            while (src_idle())
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= ch;
            waited = 0;
            do
            begin
                @(posedge clk);
                waited++;
            end
            while (!s_axis_tready);
            if (waited - 1 > longest_stall)
                longest_stall = waited - 1;
            bytes_sent++;
            parse_byte(ch, produced, r);
            if (pinned)
                pending_cmds.push_back(pin);
            else if (produced)
                pending_cmds.push_back(r);
        end
    endtask

    task automatic set_driver(input bit v);
        begin
            s_axis_tvalid <= 1'b0;
            while (pending_cmds.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid   <= 1'b0;
            drv_present = v;
            cfg_writes++;
        end
    endtask

    function automatic dir_row_t ch_row(input logic [7:0] v);
        dir_row_t row;
        begin
            row.kind   = ROW_BYTE;
            row.value  = v;
            row.pinned = 1'b0;
            row.want   = '0;
            return row;
        end
    endfunction

    function automatic dir_row_t end_row(input logic [7:0] v,
                                         input bclp_pkg::result_code_t code,
                                         input logic [bclp_pkg::DOTS_W-1:0] dots,
                                         input logic [bclp_pkg::LETTER_W-1:0] letter,
                                         input logic [bclp_pkg::CHAN_W-1:0] chan);
        dir_row_t row;
        begin
            row.kind               = ROW_BYTE;
            row.value              = v;
            row.pinned             = 1'b1;
            row.want.result_code   = code;
            row.want.dot_pattern   = dots;
            row.want.letter_index  = letter;
            row.want.test_channel  = chan;
            return row;
        end
    endfunction

    function automatic dir_row_t cfg_row(input bit v);
        dir_row_t row;
        begin
            row.kind   = ROW_CFG;
            row.value  = {7'd0, v};
            row.pinned = 1'b0;
            row.want   = '0;
            return row;
        end
    endfunction

    // one random line: command-shaped text, random printable text that may run overlong, or junk
    task automatic emit_random_line(inout int counted);
        logic [7:0] line[$];
        int         pick;
        int         len;
        int         k;
        bit         salted;
        begin
            pick   = $urandom_range(99);
            salted = 1'b1;
            if (pick < 22)
                line.push_back(8'($urandom_range(1) ? bclp_pkg::CHAR_LOWER_A
                                                    : bclp_pkg::CHAR_UPPER_A) +
                               8'($urandom_range(25)));
            else if (pick < 40)
            begin
                line.push_back($urandom_range(1) ? bclp_pkg::CHAR_UPPER_T
                                                 : bclp_pkg::CHAR_LOWER_A + 8'd19);
                case ($urandom_range(7))
                    0:       line.push_back(bclp_pkg::CHAR_ZERO - 8'd1);
                    1:       line.push_back(bclp_pkg::CHAR_FIVE + 8'd1);
                    2:       line.push_back(printable_byte());
                    default: line.push_back(bclp_pkg::CHAR_ZERO + 8'($urandom_range(5)));
                endcase
            end
            else if (pick < 48)
                line.push_back(bclp_pkg::CHAR_QUESTION);
            else if (pick < 88)
            begin
                len = $urandom_range(3) == 0 ? $urandom_range(10, 6) : $urandom_range(4);
                for (k = 0; k < len; k++)
                    line.push_back(printable_byte());
            end
            else
            begin
                salted = 1'b0;
                len = $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                    line.push_back(8'($urandom_range(255)));
            end
            if (salted)
            begin
                case ($urandom_range(2))
                    0:       line.push_back(bclp_pkg::CHAR_CR);
                    1:       line.push_back(bclp_pkg::CHAR_LF);
                    default:
                    begin
                        line.push_back(bclp_pkg::CHAR_CR);
                        line.push_back(bclp_pkg::CHAR_LF);
                    end
                endcase
            end
            foreach (line[k])
            begin
                if (salted && $urandom_range(99) < 6)
                    send_char(junk_byte(), 1'b0, '0);
                send_char(line[k], 1'b0, '0);
                if ((line[k] >= bclp_pkg::CHAR_SPACE && line[k] <= bclp_pkg::CHAR_TILDE) ||
                    line[k] == bclp_pkg::CHAR_CR || line[k] == bclp_pkg::CHAR_LF)
                    counted++;
            end
        end
    endtask

    // result side
    initial
    begin
        bclp_pkg::result_t got;
        bclp_pkg::result_t want;
        m_axis_tready <= 1'b0;
        forever
        begin
            m_axis_tready <= !(rx_hold || sink_stall());
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = bclp_pkg::result_t'(m_axis_tdata[bclp_pkg::RESULT_W-1:0]);
                cmds_seen++;
                if (int'(got.result_code) < 6)
                    code_hits[int'(got.result_code)]++;
                if (m_axis_tdata[bclp_pkg::TDATA_W-1:bclp_pkg::RESULT_W] != '0)
                    flag_mismatch($sformatf("pad bits not zero: %h", m_axis_tdata));
                if (pending_cmds.size() == 0)
                    flag_mismatch($sformatf("unexpected command %h", m_axis_tdata));
                else
                begin
                    want = pending_cmds.pop_front();
                    if (got.result_code !== want.result_code)
                        flag_mismatch($sformatf("result_code got %0d want %0d",
                                                got.result_code, want.result_code));
                    if (got.dot_pattern !== want.dot_pattern)
                        flag_mismatch($sformatf("dot_pattern got %h want %h",
                                                got.dot_pattern, want.dot_pattern));
                    if (got.letter_index !== want.letter_index)
                        flag_mismatch($sformatf("letter_index got %0d want %0d",
                                                got.letter_index, want.letter_index));
                    if (got.test_channel !== want.test_channel)
                        flag_mismatch($sformatf("test_channel got %0d want %0d",
                                                got.test_channel, want.test_channel));
                end
            end
        end
    end

    // long receiver hold-off so the parser backs up into its input
    initial
    begin
        int n;
        rx_hold <= 1'b0;
        wait (squeeze_go === 1'b1);
        @(posedge clk);
        for (n = 0; n < HOLD_CYCLES; n++)
        begin
            rx_hold <= 1'b1;
            @(posedge clk);
        end
        rx_hold <= 1'b0;
    end

    initial
    begin
        int       i;
        int       ph;
        int       counted;
        dir_row_t row;

        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        squeeze_go    <= 1'b0;
        flow          = FLOW_FREE;
        errors        = 0;
        cycles        = 0;
        bytes_sent    = 0;
        cmds_seen     = 0;
        cfg_writes    = 0;
        longest_stall = 0;
        foreach (code_hits[i])
            code_hits[i] = 0;
        ln_count      = 0;
        ln_overlong   = 1'b0;
        ln_first      = '0;
        ln_second     = '0;
        drv_present   = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(ch_row("A"));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_CR, bclp_pkg::CODE_LETTER,
                                   6'h01, 5'd0, 3'd0));
        dir_rows.push_back(ch_row("z"));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_LF, bclp_pkg::CODE_LETTER,
                                   6'h35, 5'd25, 3'd0));
        dir_rows.push_back(ch_row(bclp_pkg::CHAR_LF));
        dir_rows.push_back(ch_row("?"));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_CR, bclp_pkg::CODE_DIAG,
                                   6'h00, 5'd0, 3'd0));
        dir_rows.push_back(ch_row("t"));
        dir_rows.push_back(ch_row("5"));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_CR, bclp_pkg::CODE_TEST,
                                   6'h00, 5'd0, 3'd5));
        dir_rows.push_back(ch_row("T"));
        dir_rows.push_back(ch_row("0"));
        dir_rows.push_back(ch_row(8'hFF));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_LF, bclp_pkg::CODE_TEST,
                                   6'h00, 5'd0, 3'd0));
        for (i = 0; i < LINE_MAX; i++)
            dir_rows.push_back(ch_row(bclp_pkg::CHAR_TILDE));
        dir_rows.push_back(ch_row(bclp_pkg::CHAR_SPACE));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_CR, bclp_pkg::CODE_LONG,
                                   6'h00, 5'd0, 3'd0));
        dir_rows.push_back(cfg_row(1'b0));
        dir_rows.push_back(ch_row("b"));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_CR, bclp_pkg::CODE_ABSENT,
                                   6'h00, 5'd0, 3'd0));
        dir_rows.push_back(ch_row("T"));
        dir_rows.push_back(ch_row("3"));
        dir_rows.push_back(end_row(bclp_pkg::CHAR_CR, bclp_pkg::CODE_ABSENT,
                                   6'h00, 5'd0, 3'd0));
        dir_rows.push_back(cfg_row(1'b1));

        for (i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                set_driver(row.value[0]);
            else
                send_char(row.value, row.pinned, row.want);
        end

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_driver(ph % 3 != 2);
            flow = flow_t'(ph % 4);
            if (ph == 0)
                squeeze_go <= 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS)
                emit_random_line(counted);
            // close any open line so the next register write sees an idle parser
            send_char(bclp_pkg::CHAR_LF, 1'b0, '0);
        end
        set_driver(1'b1);

        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d bytes sent, %0d commands", bytes_sent, cmds_seen);
        $display("run: letter %0d test %0d diag %0d long %0d bad %0d absent %0d",
                 code_hits[0], code_hits[1], code_hits[2],
                 code_hits[3], code_hits[4], code_hits[5]);
        $display("run: %0d driver_present writes, longest input backpressure %0d cycles",
                 cfg_writes, longest_stall);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> braille_command_line_parser_core.f
+incdir+sv
sv/bclp_pkg.sv
sv/bclp_classify.sv
sv/braille_command_line_parser_core.sv
dv/testbench.sv
